/* design/isr_pkg.sv */
// Shared types, constants and the control store for the integer sixth root block.
// No dependencies; used by design/integer_sixth_root.sv.
`default_nettype none

package isr_pkg;

  localparam int unsigned PowerN   = 6;   // exponent of the root
  localparam int unsigned LimbW    = 32;  // width of one limb of the power accumulator
  localparam int unsigned NumLimbs = 5;   // 160-bit accumulator covers (2^22)^6
  localparam int unsigned LimbIdxW = 3;
  localparam int unsigned OperandW = 128;
  localparam int unsigned RootW    = 22;
  localparam int unsigned StepW    = 3;

  typedef enum logic [1:0] {
    UOP_LOAD,  // acc <= candidate
    UOP_MUL,   // acc <= acc * candidate, one limb a cycle
    UOP_CMP,   // keep candidate bit if acc <= operand, then loop or finish
    UOP_DONE   // hand the root to the output register
  } uop_e;

  typedef struct packed {
    uop_e                op;
    logic [LimbIdxW-1:0] last_limb;
  } ctrl_word_t;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepLoad = 3'd0;
  localparam step_t StepCmp  = 3'd6;
  localparam step_t StepDone = 3'd7;

  // One bit trial: load, five multiply passes sized to the growing power, compare.
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t cw;
    cw.op        = UOP_DONE;
    cw.last_limb = '0;
    case (step)
      3'd0: begin cw.op = UOP_LOAD; cw.last_limb = 3'd0; end
      3'd1: begin cw.op = UOP_MUL;  cw.last_limb = 3'd1; end  // c^2 <  2^44
      3'd2: begin cw.op = UOP_MUL;  cw.last_limb = 3'd2; end  // c^3 <  2^66
      3'd3: begin cw.op = UOP_MUL;  cw.last_limb = 3'd2; end  // c^4 <  2^88
      3'd4: begin cw.op = UOP_MUL;  cw.last_limb = 3'd3; end  // c^5 <  2^110
      3'd5: begin cw.op = UOP_MUL;  cw.last_limb = 3'd4; end  // c^6 <  2^132
      3'd6: begin cw.op = UOP_CMP;  cw.last_limb = 3'd0; end
      3'd7: begin cw.op = UOP_DONE; cw.last_limb = 3'd0; end
      default: begin cw.op = UOP_DONE; cw.last_limb = 3'd0; end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* design/integer_sixth_root.sv */
// Integer sixth root: a zero or negative operand skips the bit search and goes straight to
// the result step. One transaction in flight; the next is accepted the cycle after the
// result is registered, so throughput is set by the single 32 x ROOT_BITS limb multiplier
// that the microcode steps through five power passes per root bit. Async active-low reset
// idles the sequencer and empties the output register.
`default_nettype none

module integer_sixth_root #(
  parameter int unsigned ROOT_BITS = 22
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [63:0]            value_high_i,
  input  wire logic        [63:0]            value_low_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [isr_pkg::RootW-1:0]          root_o
);

  localparam int unsigned BitW  = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
  localparam int unsigned ProdW = isr_pkg::LimbW + ROOT_BITS;
  localparam int unsigned AccW  = isr_pkg::NumLimbs * isr_pkg::LimbW;

  // Control state
  logic                                busy_q, busy_d;
  isr_pkg::step_t                      step_q, step_d;
  logic [isr_pkg::LimbIdxW-1:0]        limb_q, limb_d;
  logic [BitW-1:0]                     bit_q, bit_d;
  logic                                out_valid_q, out_valid_d;

  // Datapath
  logic [isr_pkg::NumLimbs-1:0][isr_pkg::LimbW-1:0] acc_q, acc_d;
  logic [ROOT_BITS-1:0]                carry_q, carry_d;
  logic [ROOT_BITS-1:0]                r_q, r_d;
  logic [isr_pkg::OperandW-1:0]        opnd_q, opnd_d;
  logic [isr_pkg::RootW-1:0]           root_q, root_d;

  isr_pkg::ctrl_word_t                 cw;
  logic [ROOT_BITS-1:0]                cand;
  logic [ProdW-1:0]                    prod;
  logic                                fits;
  logic                                in_xfer;
  logic                                out_free;
  logic                                nonpos;

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;

  assign in_xfer  = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign nonpos   = value_high_i[63] || ((value_high_i == '0) && (value_low_i == '0));

  assign cw   = isr_pkg::ucode(step_q);
  assign cand = r_q | (ROOT_BITS'(1) << bit_q);
  assign prod = ProdW'(acc_q[limb_q]) * ProdW'(cand) + ProdW'(carry_q);
  assign fits = AccW'(acc_q) <= AccW'(opnd_q);

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    limb_d      = limb_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    carry_d     = carry_q;
    r_d         = r_q;
    opnd_d      = opnd_q;
    root_d      = root_q;

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_xfer) begin
      busy_d = 1'b1;
      opnd_d = {value_high_i, value_low_i};
      r_d    = '0;
      bit_d  = BitW'(ROOT_BITS - 1);
      limb_d = '0;
      step_d = nonpos ? isr_pkg::StepDone : isr_pkg::StepLoad;
    end else if (busy_q) begin
      case (cw.op)
        isr_pkg::UOP_LOAD: begin
          acc_d    = '0;
          acc_d[0] = isr_pkg::LimbW'(cand);
          carry_d  = '0;
          limb_d   = '0;
          step_d   = step_q + isr_pkg::step_t'(1);
        end
        isr_pkg::UOP_MUL: begin
          acc_d[limb_q] = prod[isr_pkg::LimbW-1:0];
          if (limb_q == cw.last_limb) begin
            carry_d = '0;
            limb_d  = '0;
            step_d  = step_q + isr_pkg::step_t'(1);
          end else begin
            carry_d = prod[ProdW-1:isr_pkg::LimbW];
            limb_d  = limb_q + isr_pkg::LimbIdxW'(1);
          end
        end
        isr_pkg::UOP_CMP: begin
          if (fits) begin
            r_d = cand;
          end
          if (bit_q == '0) begin
            step_d = isr_pkg::StepDone;
          end else begin
            bit_d  = bit_q - BitW'(1);
            step_d = isr_pkg::StepLoad;
          end
        end
        isr_pkg::UOP_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            root_d      = isr_pkg::RootW'(r_q);
            out_valid_d = 1'b1;
            busy_d      = 1'b0;
          end
        end
        default: begin
          step_d = isr_pkg::StepDone;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= isr_pkg::StepDone;
      limb_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      limb_q      <= limb_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    carry_q <= carry_d;
    r_q     <= r_d;
    opnd_q  <= opnd_d;
    root_q  <= root_d;
  end

  // A multiply pass never runs past its last limb
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (cw.op == isr_pkg::UOP_MUL)) |-> (limb_q <= cw.last_limb))
    else $error("limb index past end of multiply pass");

  // The sixth power fits in 6*ROOT_BITS bits when it is compared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (step_q == isr_pkg::StepCmp)) |->
      ((AccW'(acc_q) >> (isr_pkg::PowerN * ROOT_BITS)) == '0))
    else $error("sixth power overflowed its width");

  // A negative operand skips straight to the result step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && value_high_i[63]) |=>
      (busy_q && (step_q == isr_pkg::StepDone)))
    else $error("negative operand did not bypass the search");

  // A result appears only out of the result step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q && (step_q == isr_pkg::StepDone)))
    else $error("result raised outside the result step");

  // An accepted transaction blocks the input until its result is registered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for integer_sixth_root: random and corner operands, checked
// against an in-bench floor sixth root predictor. Depends on design/isr_pkg.sv and
// design/integer_sixth_root.sv.
`timescale 1ns / 100ps

module tb_top;

  localparam int RootBits     = 22;
  localparam int HalfPeriod   = 6;
  localparam int StallLimit   = 20000;  // cycles without any transaction
  localparam int HoldCycles   = 1500;   // long receiver hold-off
  localparam int DrainCycles  = 500;
  localparam int ReportMax    = 10;
  localparam logic [21:0] MaxRoot = 22'd2435496;  // above the sixth root of 2^127 - 1

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } operand_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic signed [63:0]            value_high_i = '0;
  logic        [63:0]            value_low_i  = '0;
  logic                          out_stall_i  = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic [isr_pkg::RootW-1:0]     root_o;

  operand_t                  pending_operands[$];
  logic [isr_pkg::RootW-1:0] expected_roots[$];
  operand_t                  next_operand;

  int  sender_idle_pct = 0;
  int  recv_stall_pct  = 0;
  logic in_taken       = 1'b0;
  logic hold_armed     = 1'b1;
  int  hold_left       = 0;
  int  results_seen    = 0;
  int  mismatches      = 0;
  int  quiet_cycles    = 0;

  integer_sixth_root #(.ROOT_BITS(RootBits)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_high_i (value_high_i),
    .value_low_i  (value_low_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .root_o       (root_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // k^6 at full width; k < 2^22 keeps it below 2^132.
  function automatic logic [159:0] pow6_wide(input logic [21:0] k);
    logic [159:0] acc;
    logic [159:0] kw;
    kw  = {138'd0, k};
    acc = kw;
    repeat (5) acc = acc * kw;
    return acc;
  endfunction

  // Largest r with r^6 <= operand, built one bit at a time from the top.
  function automatic logic [isr_pkg::RootW-1:0] sixth_root_floor(input logic [63:0] hi,
                                                                 input logic [63:0] lo);
    logic [127:0]              operand;
    logic [isr_pkg::RootW-1:0] root;
    logic [isr_pkg::RootW-1:0] trial;
    operand = {hi, lo};
    root    = '0;
    if (hi[63] || operand == 128'd0) return '0;
    for (int b = RootBits - 1; b >= 0; b--) begin
      trial = root | (isr_pkg::RootW'(1) << b);
      if (pow6_wide(trial) <= {32'd0, operand}) root = trial;
    end
    return root;
  endfunction

  task automatic add_operand(input logic [127:0] v);
    operand_t op;
    op.hi = v[127:64];
    op.lo = v[63:0];
    pending_operands.insert(pending_operands.size(), op);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic add_random_operands(input int count);
    logic [127:0] v;
    logic [21:0]  k;
    int           kind;
    repeat (count) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1: v = rand128();
        2, 3, 4, 5: begin
          v = rand128();
          v[127] = 1'b0;
          v = v >> $urandom_range(126);
        end
        6, 7, 8: begin
          if ($urandom_range(3) == 0) k = 22'($urandom_range(64, 1));
          else k = 22'($urandom_range(MaxRoot, 1));
          v = 128'(pow6_wide(k)) + 128'($urandom_range(2)) - 128'd1;
        end
        default: begin
          // narrow operands: low half only, or a small negative
          v = {64'd0, $urandom, $urandom};
          if ($urandom_range(1) == 1) v = -v;
        end
      endcase
      add_operand(v);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [isr_pkg::RootW-1:0] want,
                               input logic [isr_pkg::RootW-1:0] got);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("mismatch %0d (%s): expected root %0d, got %0d", mismatches, what, want, got);
  endtask

  task automatic drain_phase();
    while (pending_operands.size() != 0 || in_valid_i || expected_roots.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: advance to the next operand once the current transaction is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_operands.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_operand = pending_operands.pop_front();
        value_high_i <= next_operand.hi;
        value_low_i  <= next_operand.lo;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off early in the run.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_armed && results_seen >= 3) begin
      hold_armed  <= 1'b0;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions, watch for hangs.
  always @(posedge clk_i) begin
    logic [isr_pkg::RootW-1:0] want;
    logic                      fired;
    fired = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_roots.insert(expected_roots.size(),
                              sixth_root_floor(value_high_i, value_low_i));
        fired = 1'b1;
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        fired = 1'b1;
        results_seen++;
        if (expected_roots.size() == 0) begin
          note_mismatch("unexpected result", '0, root_o);
        end else begin
          want = expected_roots.pop_front();
          if (root_o !== want) note_mismatch("root", want, root_o);
        end
      end
    end
    if (fired) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corners: zero, sign extremes, small exact powers, the widest roots.
    add_operand(128'd0);
    add_operand({128{1'b1}});
    add_operand({1'b1, 127'd0});
    add_operand({1'b0, {127{1'b1}}});
    add_operand(128'd1);
    add_operand(128'd63);
    add_operand(128'd64);
    add_operand(128'd728);
    add_operand(128'd729);
    add_operand({64'd0, {64{1'b1}}});
    add_operand({64'd1, 64'd0});
    add_operand({1'b1, 63'd0, {64{1'b1}}});
    add_operand({1'b0, {63{1'b1}}, 64'd0});
    add_operand({64'd0, 1'b1, 63'd0});
    add_operand(128'(pow6_wide(MaxRoot)));
    add_operand(128'(pow6_wide(MaxRoot)) - 128'd1);
    add_operand(128'(pow6_wide(22'd1 << 21)));
    add_operand(128'(pow6_wide(22'd1 << 21)) - 128'd1);
    add_operand(128'(pow6_wide(22'd1 << 20)) + 128'd1);
    add_operand(-128'd2);
    add_random_operands(92);
    drain_phase();

    sender_idle_pct = 79;
    recv_stall_pct  = 0;
    add_random_operands(112);
    drain_phase();

    sender_idle_pct = 0;
    recv_stall_pct  = 79;
    add_random_operands(112);
    drain_phase();

    sender_idle_pct = 33;
    recv_stall_pct  = 33;
    add_random_operands(112);
    drain_phase();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
